>>> design/rgbn_pkg.sv
// Shared types and constants for the normalized RGB chromaticity block.
// No dependencies; used by every module of the block.
package rgbn_pkg;

    localparam int BYTE_W    = 8;
    localparam int SUM_W     = 10;
    localparam int QUO_W     = 8;
    localparam int REM_W     = 16;
    localparam int DSR_W     = SUM_W + QUO_W - 1;
    localparam int SEL_W     = 2;
    localparam int DIV_STEPS = QUO_W;

    localparam logic [SEL_W-1:0] SEL_ZERO = 2'd0;
    localparam logic [SEL_W-1:0] SEL_ONE  = 2'd1;
    localparam logic [SEL_W-1:0] SEL_TWO  = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [REM_W-1:0] rem;
        logic [DSR_W-1:0] dsr;
        logic [QUO_W-1:0] quo;
    } stage_t;

endpackage

>>> design/normalized_rgb_channel.sv
// Top level of the normalized RGB chromaticity block.
// Depends on rgbn_pkg, rgbn_front and rgbn_div_stage.
//
// Usage:
// A request is taken at every rising edge where start is high; busy is always
// low, so a pixel may be presented in every cycle. The three pixel bytes come
// on byte_zero, byte_one and byte_two in memory order.
// The result, 255 times the selected byte divided by the byte sum (zero for a
// zero sum), appears on normalized_value with done high for exactly one cycle.
// The result passes through one front stage (select, sum, scale) and eight
// restoring division stages, one quotient bit each. Throughput is one pixel
// per cycle.
// The receiver cannot stall; results are not held.
// The user writes channel_select through cfg_we and cfg_data only while the
// block is idle; the block does not enforce this. Reset clears the pipeline
// valid bits, sets channel_select to zero and discards requests in flight.
module normalized_rgb_channel
    import rgbn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [BYTE_W-1:0] byte_zero,
    input  logic [BYTE_W-1:0] byte_one,
    input  logic [BYTE_W-1:0] byte_two,
    input  logic              cfg_we,
    input  logic [SEL_W-1:0]  cfg_data,
    output logic              done,
    output logic [QUO_W-1:0]  normalized_value
);

    logic [SEL_W-1:0] channel_select_reg;
    stage_t           pipe [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_select_reg <= SEL_ZERO;
        end
        else if (cfg_we)
        begin
            channel_select_reg <= cfg_data;
        end
    end

    assign busy = 1'b0;

    rgbn_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (start),
        .channel_select (channel_select_reg),
        .byte_zero      (byte_zero),
        .byte_one       (byte_one),
        .byte_two       (byte_two),
        .stage_out      (pipe[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        rgbn_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (pipe[i]),
            .stage_out (pipe[i+1])
        );
    end

    assign done             = pipe[DIV_STEPS].valid;
    assign normalized_value = pipe[DIV_STEPS].quo;

endmodule

>>> design/rgbn_front.sv
// Front stage: channel selection, byte sum and scaling by full scale.
// Depends on rgbn_pkg.
module rgbn_front
    import rgbn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [SEL_W-1:0]  channel_select,
    input  logic [BYTE_W-1:0] byte_zero,
    input  logic [BYTE_W-1:0] byte_one,
    input  logic [BYTE_W-1:0] byte_two,
    output stage_t            stage_out
);

    logic [BYTE_W-1:0] pick;
    logic [SUM_W-1:0]  total;
    logic [SUM_W-1:0]  divisor;
    logic [REM_W-1:0]  dividend;
    stage_t            stage_next;
    stage_t            stage_reg;

    always_comb
    begin
        unique case (channel_select)
            SEL_ZERO: pick = byte_zero;
            SEL_ONE:  pick = byte_one;
            SEL_TWO:  pick = byte_two;
            default:  pick = '0;
        endcase
    end

    assign total = {2'b00, byte_zero} + {2'b00, byte_one} + {2'b00, byte_two};

    // A zero sum implies a zero pick; a divisor of one then yields a zero quotient.
    assign divisor  = (total == '0) ? SUM_W'(1) : total;
    assign dividend = {pick, 8'h00} - {8'h00, pick};

    always_comb
    begin
        stage_next.valid = in_valid;
        stage_next.rem   = dividend;
        stage_next.dsr   = {divisor, {(QUO_W-1){1'b0}}};
        stage_next.quo   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

>>> design/rgbn_div_stage.sv
// One restoring division step: one quotient bit per stage, divisor shifted down.
// Depends on rgbn_pkg.
module rgbn_div_stage
    import rgbn_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  stage_t stage_in,
    output stage_t stage_out
);

    logic           fits;
    logic [DSR_W:0] diff;
    stage_t         stage_next;
    stage_t         stage_reg;

    assign diff = {2'b00, stage_in.rem} - {1'b0, stage_in.dsr};
    assign fits = ~diff[DSR_W];

    always_comb
    begin
        stage_next.valid = stage_in.valid;
        stage_next.rem   = fits ? diff[REM_W-1:0] : stage_in.rem;
        stage_next.dsr   = {1'b0, stage_in.dsr[DSR_W-1:1]};
        stage_next.quo   = {stage_in.quo[QUO_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule
